FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the occupancy monitor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("occupancy monitor assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("occupancy monitor assertion failed");

`endif

FILE: hw/rtl/occ_twm_pkg.sv
// Package with the shared widths and register codes of the occupancy monitor.
package occ_twm_pkg;

	localparam int unsigned ACC_W  = 48;  // histogram bins and total time
	localparam int unsigned WSUM_W = 54;  // level-weighted time sum
	localparam int unsigned TS_W   = 32;  // time stamp port
	localparam int unsigned MEAN_W = 22;  // mean level port
	localparam int unsigned LVL_PW = 6;   // current level port
	localparam int unsigned CFG_W  = 8;   // configuration data

	typedef enum logic [1:0] {
		REG_STATION = 2'd0,
		REG_UP_KIND = 2'd1,
		REG_DN_KIND = 2'd2
	} cfg_reg_t;

endpackage

FILE: hw/rtl/occupancy_time_weighted_mean_top.sv
// Each input transfer steps through the read, update and start states and the serial
// divider, which takes no division steps when no time has elapsed yet or the mean
// saturates. A new item is taken only once the last result is in the output register,
// where it may wait while the next item is taken. Reset clears control state and then
// sweeps the histogram memory, one bin a cycle, with in_ready low.
`include "assert_macros.svh"

module occupancy_time_weighted_mean_top
	import occ_twm_pkg::*;
#(
	parameter int unsigned MAX_LEVELS = 64,
	parameter int unsigned TIME_BITS  = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        station_id,
	input  logic [1:0]        event_kind,
	input  logic [TS_W-1:0]   time_stamp,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              accepted,
	output logic [MEAN_W-1:0] mean_level,
	output logic [LVL_PW-1:0] current_level,
	output logic [ACC_W-1:0]  bin_time,
	output logic              clamped
);

	localparam int unsigned LVL_W = $clog2(MAX_LEVELS);
	localparam int unsigned NQ    = LVL_W + FRAC_BITS;
	localparam int unsigned TW    = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;
	localparam int unsigned PW    = LVL_W + TW;
	localparam int unsigned MX_W  = (NQ > MEAN_W) ? NQ : MEAN_W;
	localparam int unsigned LX_W  = (LVL_W > LVL_PW) ? LVL_W : LVL_PW;
	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(MAX_LEVELS - 1);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_UPD   = 7'b0001000,
		ST_START = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [7:0]        station_match_q;
	logic [1:0]        up_kind_q;
	logic [1:0]        down_kind_q;
	logic [LVL_W-1:0]  level_q;
	logic [TW-1:0]     last_time_q;
	logic [ACC_W-1:0]  total_q;
	logic [WSUM_W-1:0] wsum_q;
	logic [LVL_W-1:0]  clr_idx_q;

	logic [1:0]        kind_q;
	logic              match_q;
	logic [TW-1:0]     delta_q;
	logic [PW-1:0]     prod_q;
	logic [ACC_W-1:0]  bin_q;
	logic              clamped_q;

	logic              out_valid_q;
	logic              accepted_q;
	logic [MEAN_W-1:0] mean_q;
	logic [LVL_PW-1:0] level_out_q;
	logic [ACC_W-1:0]  bin_out_q;
	logic              clamped_out_q;

	logic              in_xfer;
	logic              in_match;
	logic [TW-1:0]     ts;
	logic              out_load;
	logic              mem_we;
	logic [LVL_W-1:0]  mem_waddr;
	logic [ACC_W-1:0]  mem_wdata;
	logic [ACC_W-1:0]  mem_rdata;
	logic [ACC_W:0]    bin_sum;
	logic [ACC_W-1:0]  bin_new;
	logic [ACC_W:0]    total_sum;
	logic [WSUM_W:0]   wsum_sum;
	logic              div_start;
	logic              div_done;
	logic [NQ-1:0]     div_quot;
	logic [MX_W-1:0]   mean_ext;
	logic [LX_W-1:0]   level_ext;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign ts        = time_stamp[TW-1:0];
	assign in_match  = (station_id == station_match_q);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign div_start = (state_q == ST_START);

	// Saturating accumulations for a matching event.
	assign bin_sum   = {1'b0, mem_rdata} + (ACC_W + 1)'(delta_q);
	assign bin_new   = bin_sum[ACC_W] ? '1 : bin_sum[ACC_W-1:0];
	assign total_sum = {1'b0, total_q} + (ACC_W + 1)'(delta_q);
	assign wsum_sum  = {1'b0, wsum_q} + (WSUM_W + 1)'(prod_q);

	assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPD) && match_q);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_idx_q : level_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : bin_new;

	occ_twm_hist_mem #(
		.DEPTH (MAX_LEVELS),
		.AW    (LVL_W),
		.DW    (ACC_W)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_xfer),
		.raddr (level_q),
		.rdata (mem_rdata)
	);

	occ_twm_div #(
		.MAX_LEVELS (MAX_LEVELS),
		.LVL_W      (LVL_W),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (wsum_q),
		.den    (total_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_match_q <= '0;
			up_kind_q       <= 2'd1;
			down_kind_q     <= 2'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STATION: station_match_q <= cfg_data;
				REG_UP_KIND: up_kind_q       <= cfg_data[1:0];
				REG_DN_KIND: down_kind_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and running state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			level_q     <= '0;
			last_time_q <= '0;
			total_q     <= '0;
			wsum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == LVL_TOP) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_READ;
						if (in_match) begin
							last_time_q <= ts;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_START;
					if (match_q) begin
						total_q <= total_sum[ACC_W] ? '1 : total_sum[ACC_W-1:0];
						wsum_q  <= wsum_sum[WSUM_W] ? '1 : wsum_sum[WSUM_W-1:0];
						if (kind_q == up_kind_q) begin
							if (level_q != LVL_TOP) begin
								level_q <= level_q + 1'b1;
							end
						end else if (kind_q == down_kind_q) begin
							if (level_q != '0) begin
								level_q <= level_q - 1'b1;
							end
						end
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q  <= event_kind;
			match_q <= in_match;
			delta_q <= (ts >= last_time_q) ? (ts - last_time_q) : '0;
		end
		if (state_q == ST_READ) begin
			prod_q <= PW'(level_q) * PW'(delta_q);
		end
		if (state_q == ST_UPD) begin
			bin_q     <= match_q ? bin_new : '0;
			clamped_q <= match_q && (((kind_q == up_kind_q) && (level_q == LVL_TOP)) ||
				((kind_q != up_kind_q) && (kind_q == down_kind_q) && (level_q == '0)));
		end
	end

	assign mean_ext  = MX_W'(div_quot);
	assign level_ext = LX_W'(level_q);

	// Output register: holds the result until its transfer completes.
	always_ff @(posedge clk) begin
		if (out_load) begin
			accepted_q    <= match_q;
			mean_q        <= mean_ext[MEAN_W-1:0];
			level_out_q   <= level_ext[LVL_PW-1:0];
			bin_out_q     <= bin_q;
			clamped_out_q <= clamped_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign mean_level    = mean_q;
	assign current_level = level_out_q;
	assign bin_time      = bin_out_q;
	assign clamped       = clamped_out_q;

	`OCC_ASSERT_NEXT(a_xfer_reads, clk, arst_n, in_xfer, state_q == ST_READ)
	`OCC_ASSERT_NOW(a_load_free, clk, arst_n, out_load, !out_valid_q || out_ready)
	`OCC_ASSERT_NEXT(a_level_hold, clk, arst_n, state_q != ST_UPD, level_q == $past(level_q))
	`OCC_ASSERT_NOW(a_clamp_bound, clk, arst_n, out_load && clamped_q,
		level_q == '0 || level_q == LVL_TOP)

endmodule

FILE: hw/rtl/occ_twm_hist_mem.sv
// Histogram store: single-port write, registered read, one entry per level.
module occ_twm_hist_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned DW    = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/occ_twm_div.sv
// Restoring divider giving the saturated mean level, one quotient bit a cycle.
`include "assert_macros.svh"

module occ_twm_div
	import occ_twm_pkg::*;
#(
	parameter int unsigned MAX_LEVELS = 64,
	parameter int unsigned LVL_W      = 6,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [WSUM_W-1:0]        num,
	input  logic [ACC_W-1:0]         den,
	output logic                     done,
	output logic [LVL_W+FRAC_BITS-1:0] quot
);

	localparam int unsigned NQ  = LVL_W + FRAC_BITS;
	localparam int unsigned CW  = $clog2(NQ + 1);
	localparam logic [NQ-1:0] TOP = NQ'(MAX_LEVELS - 1) << FRAC_BITS;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [ACC_W-1:0] rem_q;
	logic [NQ-1:0] low_q;
	logic [NQ-1:0] quot_q;

	logic [WSUM_W-1:0] num_hi;
	logic              ovf;
	logic [ACC_W:0]    trial;
	logic              ge;
	logic [ACC_W:0]    diff;
	logic [NQ-1:0]     quot_nx;

	// The dividend is num scaled by the fraction bits. Its part above the
	// quotient width must stay below den, otherwise the mean saturates.
	assign num_hi  = num >> LVL_W;
	assign ovf     = num_hi >= WSUM_W'(den);
	assign trial   = {rem_q, low_q[NQ-1]};
	assign ge      = trial >= {1'b0, den};
	assign diff    = trial - {1'b0, den};
	assign quot_nx = (quot_q << 1) | NQ'(ge);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0 || ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(NQ);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num_hi[ACC_W-1:0];
			low_q  <= NQ'(num[LVL_W-1:0]) << FRAC_BITS;
			if (den == '0) begin
				quot_q <= '0;
			end else if (ovf) begin
				quot_q <= TOP;
			end else begin
				quot_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
			low_q <= low_q << 1;
			// On the last step the quotient is clipped to the top level.
			if (cnt_q == CW'(1) && quot_nx > TOP) begin
				quot_q <= TOP;
			end else begin
				quot_q <= quot_nx;
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	`OCC_ASSERT_NOW(a_no_restart, clk, arst_n, start, !busy_q)
	`OCC_ASSERT_NOW(a_quot_in_range, clk, arst_n, done_q, quot_q <= TOP)

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the occupancy monitor's time-weighted mean level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import occ_twm_pkg::*;

	localparam int unsigned LEVELS = 64;
	localparam int unsigned FRAC = 16;
	localparam realtime HALF_PERIOD = 4ns;
	localparam int RESET_CYCLES = 9;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_EVENTS = 480;
	localparam logic [MEAN_W-1:0] MEAN_TOP = MEAN_W'((LEVELS - 1) << FRAC);

	typedef struct packed {
		logic              accepted;
		logic [MEAN_W-1:0] mean;
		logic [LVL_PW-1:0] lvl;
		logic [ACC_W-1:0]  bin;
		logic              clamped;
	} occ_result_t;

	// Tracks the monitor's level, histogram and running sums, and holds the
	// results still owed by the block in transfer order.
	class level_mean_tracker;
		logic [7:0]        station;
		logic [1:0]        up_kind;
		logic [1:0]        down_kind;
		logic [LVL_PW-1:0] level;
		logic [TS_W-1:0]   last_stamp;
		logic [ACC_W-1:0]  bin_ticks [LEVELS];
		logic [ACC_W-1:0]  total_ticks;
		logic [WSUM_W-1:0] weighted_ticks;
		occ_result_t       due_results [$];
		int errors;
		int checked;
		int matched;
		int clamps;
		int ceiling_means;

		function new();
			station = '0;
			up_kind = 2'd1;
			down_kind = 2'd2;
			level = '0;
			last_stamp = '0;
			foreach (bin_ticks[i])
				bin_ticks[i] = '0;
			total_ticks = '0;
			weighted_ticks = '0;
			errors = 0;
			checked = 0;
			matched = 0;
			clamps = 0;
			ceiling_means = 0;
		endfunction

		function void apply_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_STATION: station = value;
				REG_UP_KIND: up_kind = value[1:0];
				REG_DN_KIND: down_kind = value[1:0];
				default: ;
			endcase
		endfunction

		function logic [ACC_W-1:0] clip_acc(logic [ACC_W-1:0] a, logic [TS_W-1:0] b);
			logic [ACC_W:0] sum;
			sum = {1'b0, a} + b;
			return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
		endfunction

		// Once the quotient reaches the top level the mean is pinned there.
		function logic [MEAN_W-1:0] running_mean();
			logic [WSUM_W-1:0] whole;
			logic [WSUM_W+FRAC-1:0] scaled;
			if (total_ticks == '0)
				return '0;
			whole = weighted_ticks / total_ticks;
			if (whole >= LEVELS - 1)
				return MEAN_TOP;
			scaled = {weighted_ticks, {FRAC{1'b0}}};
			return MEAN_W'(scaled / total_ticks);
		endfunction

		function void note_event(logic [7:0] sid, logic [1:0] kind, logic [TS_W-1:0] stamp);
			occ_result_t want;
			logic [TS_W-1:0] elapsed;
			logic [WSUM_W:0] wsum_next;
			want = '0;
			if (sid == station) begin
				matched++;
				// Time running backwards adds nothing, but the new stamp is kept.
				elapsed = (stamp >= last_stamp) ? stamp - last_stamp : '0;
				bin_ticks[level] = clip_acc(bin_ticks[level], elapsed);
				want.bin = bin_ticks[level];
				total_ticks = clip_acc(total_ticks, elapsed);
				wsum_next = {1'b0, weighted_ticks} + level * elapsed;
				weighted_ticks = wsum_next[WSUM_W] ? '1 : wsum_next[WSUM_W-1:0];
				last_stamp = stamp;
				if (kind == up_kind) begin
					if (level == LEVELS - 1)
						want.clamped = 1'b1;
					else
						level = level + 1'b1;
				end else if (kind == down_kind) begin
					if (level == '0)
						want.clamped = 1'b1;
					else
						level = level - 1'b1;
				end
				want.accepted = 1'b1;
				if (want.clamped)
					clamps++;
			end
			want.mean = running_mean();
			want.lvl = level;
			if (want.mean == MEAN_TOP)
				ceiling_means++;
			due_results.push_back(want);
		endfunction

		function void check_result(logic acc, logic [MEAN_W-1:0] mean, logic [LVL_PW-1:0] lvl,
			logic [ACC_W-1:0] bin, logic clmp);
			occ_result_t want;
			checked++;
			if (due_results.size() == 0) begin
				$error("result transfer with no event outstanding");
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (acc !== want.accepted) begin
				$error("accepted: expected %0d, got %0d", want.accepted, acc);
				errors++;
			end
			if (mean !== want.mean) begin
				$error("mean_level: expected 0x%0h, got 0x%0h", want.mean, mean);
				errors++;
			end
			if (lvl !== want.lvl) begin
				$error("current_level: expected %0d, got %0d", want.lvl, lvl);
				errors++;
			end
			if (bin !== want.bin) begin
				$error("bin_time: expected 0x%0h, got 0x%0h", want.bin, bin);
				errors++;
			end
			if (clmp !== want.clamped) begin
				$error("clamped: expected %0d, got %0d", want.clamped, clmp);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        station_id;
	logic [1:0]        event_kind;
	logic [TS_W-1:0]   time_stamp;
	logic              out_valid;
	logic              out_ready;
	logic              accepted;
	logic [MEAN_W-1:0] mean_level;
	logic [LVL_PW-1:0] current_level;
	logic [ACC_W-1:0]  bin_time;
	logic              clamped;

	level_mean_tracker sb;
	logic [TS_W-1:0] ticks;
	int burst_left;
	int events_sent;
	int hold_offs;
	int idle_cycles;
	bit hold_off_req;

	occupancy_time_weighted_mean_top #(
		.MAX_LEVELS(LEVELS),
		.TIME_BITS(TS_W),
		.FRAC_BITS(FRAC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.station_id(station_id),
		.event_kind(event_kind),
		.time_stamp(time_stamp),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.mean_level(mean_level),
		.current_level(current_level),
		.bin_time(bin_time),
		.clamped(clamped)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_event(logic [7:0] sid, logic [1:0] kind, logic [TS_W-1:0] stamp);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		station_id <= sid;
		event_kind <= kind;
		time_stamp <= stamp;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_event(sid, kind, stamp);
		ticks = stamp;
		events_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.due_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.apply_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic configure(logic [7:0] station, logic [1:0] up, logic [1:0] down);
		set_reg(REG_STATION, station);
		set_reg(REG_UP_KIND, CFG_W'(up));
		set_reg(REG_DN_KIND, CFG_W'(down));
		cfg_valid <= 1'b0;
	endtask

	// Runs under the reset settings: station 0, kind 1 raises, kind 2 lowers.
	task automatic run_directed();
		send_event(8'd0, 2'd2, '0);
		send_event(8'hFF, 2'd3, '1);
		send_event(8'd0, 2'd0, '0);
		// Climb to the top without any time passing, so that the next stretch of time
		// is spent at the top level and the mean sits exactly on its ceiling.
		repeat (LEVELS - 1)
			send_event(8'd0, 2'd1, '0);
		send_event(8'd0, 2'd1, '0);
		send_event(8'd0, 2'd3, TS_W'(100));
		send_event(8'h80, 2'd1, '0);
		send_event(8'd0, 2'd2, '0);
		send_event(8'd0, 2'd2, '1);
		send_event(8'd0, 2'd1, 32'h8000_0000);
		send_event(8'd0, 2'd3, 32'h8000_0000);
		send_event(8'h01, 2'd0, 32'h0000_0001);
		send_event(8'd0, 2'd0, '1);
	endtask

	// Mostly runs of well-formed events for the watched station: wandering,
	// climbing to the top, draining to zero, with time jumps and noise mixed in.
	task automatic run_random(int quota);
		int taken;
		int run_len;
		int style;
		int pick;
		logic [7:0] sid;
		logic [1:0] kind;
		logic [TS_W-1:0] stamp;
		taken = 0;
		while (taken < quota) begin
			style = $urandom_range(0, 9);
			run_len = (style >= 5 && style <= 7) ? $urandom_range(40, 80) : $urandom_range(4, 40);
			repeat (run_len) begin
				sid = sb.station;
				kind = 2'($urandom_range(0, 3));
				stamp = ticks + (($urandom_range(0, 3) == 0) ? '0 : TS_W'($urandom_range(1, 2000)));
				case (style)
					5, 6: kind = sb.up_kind;
					7: kind = sb.down_kind;
					8: begin
						sid = 8'($urandom);
						stamp = TS_W'($urandom);
					end
					9: stamp = ($urandom_range(0, 1) == 1) ? ticks + TS_W'($urandom)
						: ticks - TS_W'($urandom_range(1, 5000));
					default: begin
						pick = $urandom_range(0, 9);
						if (pick < 4)
							kind = sb.up_kind;
						else if (pick < 8)
							kind = sb.down_kind;
						if ($urandom_range(0, 7) == 0)
							sid = 8'($urandom);
					end
				endcase
				send_event(sid, kind, stamp);
				if (sid == sb.station)
					taken++;
			end
		end
	endtask

	// Result side: stretches of steady, patchy and scarce acceptance, and on
	// request one long hold-off so that the block backs up into its input.
	initial begin
		int mode;
		int seg;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			seg = $urandom_range(10, 150);
			repeat (seg) begin
				@(negedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) == 0);
					default: out_ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_offs++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(accepted, mean_level, current_level, bin_time, clamped);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		sb = new();
		ticks = '0;
		burst_left = 0;
		events_sent = 0;
		hold_offs = 0;
		idle_cycles = 0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		station_id = '0;
		event_kind = '0;
		time_stamp = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();
		wait_idle();

		configure(8'hFF, 2'd0, 2'd3);
		hold_off_req = 1'b1;
		run_random(PHASE_EVENTS);
		wait_idle();

		// Equal kinds: every watched event of kind 2 raises the level, as the raise check comes first.
		configure(8'h5A, 2'd2, 2'd2);
		run_random(PHASE_EVENTS / 2);
		wait_idle();

		configure(8'($urandom_range(1, 254)), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
		hold_off_req = 1'b1;
		run_random(PHASE_EVENTS);
		wait_idle();

		configure(8'h00, 2'd3, 2'd0);
		run_random(PHASE_EVENTS);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d events, %0d for the watched station, over five register settings.",
			events_sent, sb.matched);
		$display("Checked %0d results: %0d level clamps, %0d means at the ceiling, %0d long stalls.",
			sb.checked, sb.clamps, sb.ceiling_means, hold_offs);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
